// ===== src/nch_pkg.sv =====
// Shared constants and the popcount function for the nearest-centroid Hamming block.
package nch_pkg;

    // Store geometry; the index fields of the item ports take their widths from it.
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_WORDS    = 4;
    localparam int CIDX_W       = $clog2(MAX_CLUSTERS);
    localparam int WIDX_W       = $clog2(MAX_WORDS);
    localparam int ADDR_W       = CIDX_W + WIDX_W;

    // Field widths.
    localparam int DATA_W    = 64;
    localparam int CLUSTER_W = 5;
    localparam int DIST_W    = 9;
    localparam int POP_W     = 7;
    localparam int KCFG_W    = 5;
    localparam int WCFG_W    = 3;
    localparam int CFG_W     = 5;

    // Accumulator ceiling.
    localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_IDX_CLUSTERS = 1'b0;
    localparam logic CFG_IDX_WORDS    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [KCFG_W-1:0] CLUSTERS_RESET = 5'd16;
    localparam logic [WCFG_W-1:0] WORDS_RESET    = 3'd4;

    // Number of ones in a 64-bit word, summed as a balanced adder tree.
    function automatic logic [POP_W-1:0] popcount64(input logic [DATA_W-1:0] x);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++)
        begin
            l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

// ===== src/nearest_centroid_hamming_assign_top.sv =====
// Nearest-centroid assignment by Hamming distance over a stored set of binary centroids.
//
// Usage: items arrive on the input channel (in_valid / in_stall). A load item
// (mode 0) writes one 64-bit centroid word into the centroid memory; the block
// stays ready for the next item. A query item (mode 1) carries one descriptor
// word; the block walks the active centroids one per cycle through a
// three-stage read-modify-write loop (read centroid word and accumulator,
// popcount, add and write back). The input channel stalls while the walk runs.
// Query words with word_index at or beyond active_words are dropped. On the
// last word the same walk also compares each distance against the running
// best, and one result item goes to the output register through the push
// state once the output slot is free.
// The output channel (out_valid / out_stall) has its own register, so the
// block takes new items while a result waits; if a second result is ready
// while the first is still stalled, the block holds until the slot frees.
// Reset clears all control state, the accumulator valid bits and sets the
// configuration to 16 clusters and 4 words; centroid words are undefined
// until written. Configuration writes are taken at any edge with cfg_wen.
module nearest_centroid_hamming_assign_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration port
    input  logic                           cfg_wen,
    input  logic                           cfg_addr,
    input  logic [nch_pkg::CFG_W-1:0]      cfg_wdata,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [nch_pkg::CIDX_W-1:0]     centroid_index,
    input  logic [nch_pkg::WIDX_W-1:0]     word_index,
    input  logic [nch_pkg::DATA_W-1:0]     data_word,
    input  logic [nch_pkg::CLUSTER_W-1:0]  prior_cluster,
    input  logic [nch_pkg::DIST_W-1:0]     prior_distance,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [nch_pkg::CLUSTER_W-1:0]  cluster,
    output logic [nch_pkg::DIST_W-1:0]     distance,
    output logic                           changed
);
    import nch_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    state_t                  state_reg;
    logic [KCFG_W-1:0]       clusters_cfg_reg;
    logic [WCFG_W-1:0]       words_cfg_reg;

    // Memories and their registered read data.
    logic [DATA_W-1:0]       cent_mem [MAX_CLUSTERS*MAX_WORDS];
    logic [DIST_W-1:0]       dist_mem [MAX_CLUSTERS];
    logic [DATA_W-1:0]       cent_rd_reg;
    logic [DIST_W-1:0]       dist_rd_reg;
    logic [MAX_CLUSTERS-1:0] dist_vld_reg;

    // Latched query item.
    logic [DATA_W-1:0]       query_reg;
    logic [WIDX_W-1:0]       widx_reg;
    logic                    last_reg;

    // Walk counter and pipeline stages.
    logic [CIDX_W-1:0]       cnt_reg;
    logic                    s1_vld_reg;
    logic                    s1_end_reg;
    logic [CIDX_W-1:0]       s1_idx_reg;
    logic                    s2_vld_reg;
    logic                    s2_end_reg;
    logic [CIDX_W-1:0]       s2_idx_reg;
    logic [POP_W-1:0]        pop_reg;
    logic [DIST_W-1:0]       acc_reg;

    // Running best and output register.
    logic [CLUSTER_W-1:0]    best_c_reg;
    logic [DIST_W-1:0]       best_d_reg;
    logic                    moved_reg;
    logic                    out_vld_reg;
    logic [CLUSTER_W-1:0]    out_c_reg;
    logic [DIST_W-1:0]       out_d_reg;
    logic                    out_chg_reg;

    logic                    in_acc;
    logic                    load_we;
    logic [KCFG_W-1:0]       k_eff;
    logic [WCFG_W-1:0]       nw_eff;
    logic                    query_in_range;
    logic                    issue_end;
    logic [DIST_W:0]         sum_wide;
    logic [DIST_W-1:0]       sum_sat;
    logic                    improve;
    logic                    out_free;
    logic [POP_W-1:0]        pop_next;
    logic [DIST_W-1:0]       acc_next;

    // Clamp the configuration registers to the usable range.
    always_comb
    begin
        if (clusters_cfg_reg == '0)
            k_eff = KCFG_W'(1);
        else if (clusters_cfg_reg > KCFG_W'(MAX_CLUSTERS))
            k_eff = KCFG_W'(MAX_CLUSTERS);
        else
            k_eff = clusters_cfg_reg;

        if (words_cfg_reg == '0)
            nw_eff = WCFG_W'(1);
        else if (words_cfg_reg > WCFG_W'(MAX_WORDS))
            nw_eff = WCFG_W'(MAX_WORDS);
        else
            nw_eff = words_cfg_reg;
    end

    // Input handshake and item decode.
    assign in_stall       = (state_reg != ST_IDLE);
    assign in_acc         = in_valid && !in_stall;
    assign load_we        = in_acc && (mode == MODE_LOAD);
    assign query_in_range = {1'b0, word_index} < nw_eff;
    assign issue_end      = ({1'b0, cnt_reg} == (k_eff - KCFG_W'(1)));

    // Stage one: popcount of the difference and the accumulator seen so far.
    assign pop_next = popcount64(query_reg ^ cent_rd_reg);
    assign acc_next = dist_vld_reg[s1_idx_reg] ? dist_rd_reg : '0;

    // Stage two: saturating add and strict-improvement test.
    assign sum_wide = {1'b0, acc_reg} + (DIST_W+1)'(pop_reg);
    assign sum_sat  = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
    assign improve  = last_reg && (sum_sat < best_d_reg);

    assign out_free = !out_vld_reg || !out_stall;

    // Centroid memory: one write port for loads, one read port for the walk.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            cent_mem[{centroid_index, word_index}] <= data_word;
        end
        cent_rd_reg <= cent_mem[{cnt_reg, widx_reg}];
    end

    // Accumulator memory: read at the walk counter, written back from stage two.
    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            dist_mem[s2_idx_reg] <= sum_sat;
        end
        dist_rd_reg <= dist_mem[cnt_reg];
    end

    // Payload registers: latched query and pipeline data.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            query_reg <= data_word;
            widx_reg  <= word_index;
        end
        pop_reg <= pop_next;
        acc_reg <= acc_next;
    end

    // Control: configuration, walk sequencer, running best and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            clusters_cfg_reg <= CLUSTERS_RESET;
            words_cfg_reg    <= WORDS_RESET;
            dist_vld_reg     <= '0;
            last_reg         <= 1'b0;
            cnt_reg          <= '0;
            s1_vld_reg       <= 1'b0;
            s1_end_reg       <= 1'b0;
            s1_idx_reg       <= '0;
            s2_vld_reg       <= 1'b0;
            s2_end_reg       <= 1'b0;
            s2_idx_reg       <= '0;
            best_c_reg       <= '0;
            best_d_reg       <= '0;
            moved_reg        <= 1'b0;
            out_vld_reg      <= 1'b0;
            out_c_reg        <= '0;
            out_d_reg        <= '0;
            out_chg_reg      <= 1'b0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_wen)
            begin
                unique case (cfg_addr)
                    CFG_IDX_CLUSTERS: clusters_cfg_reg <= cfg_wdata[KCFG_W-1:0];
                    CFG_IDX_WORDS:    words_cfg_reg    <= cfg_wdata[WCFG_W-1:0];
                    default:          ;
                endcase
            end

            // Output slot empties when the receiver takes the item and no new
            // result is pushed in its place.
            if (out_vld_reg && !out_stall && (state_reg != ST_PUSH))
            begin
                out_vld_reg <= 1'b0;
            end

            // Pipeline advance.
            s1_vld_reg <= (state_reg == ST_SCAN);
            s1_end_reg <= (state_reg == ST_SCAN) && issue_end;
            s1_idx_reg <= cnt_reg;
            s2_vld_reg <= s1_vld_reg;
            s2_end_reg <= s1_end_reg;
            s2_idx_reg <= s1_idx_reg;

            // Write-back marks the accumulator as holding a value for this descriptor.
            if (s2_vld_reg)
            begin
                dist_vld_reg[s2_idx_reg] <= 1'b1;
                if (improve)
                begin
                    if (best_c_reg != {1'b0, s2_idx_reg})
                        moved_reg <= 1'b1;
                    best_c_reg <= {1'b0, s2_idx_reg};
                    best_d_reg <= sum_sat;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (mode == MODE_QUERY) && query_in_range)
                    begin
                        if (word_index == '0)
                            dist_vld_reg <= '0;
                        last_reg   <= ({1'b0, word_index} == (nw_eff - WCFG_W'(1)));
                        best_c_reg <= prior_cluster;
                        best_d_reg <= prior_distance;
                        moved_reg  <= 1'b0;
                        cnt_reg    <= '0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issue_end)
                        state_reg <= ST_DRAIN;
                    else
                        cnt_reg <= cnt_reg + CIDX_W'(1);
                end
                ST_DRAIN:
                begin
                    if (s2_vld_reg && s2_end_reg)
                        state_reg <= last_reg ? ST_PUSH : ST_IDLE;
                end
                ST_PUSH:
                begin
                    if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                        out_c_reg   <= best_c_reg;
                        out_d_reg   <= best_d_reg;
                        out_chg_reg <= moved_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_vld_reg;
    assign cluster   = out_c_reg;
    assign distance  = out_d_reg;
    assign changed   = out_chg_reg;

endmodule
